[hw/rtl/gno_pkg.sv]
// Shared constants, codes and widths for the occupancy grid distance block.
`default_nettype none
package gno_pkg;
  localparam int GRID_X = 32;
  localparam int GRID_Y = 32;
  localparam int GRID_Z = 32;

  localparam int XW = $clog2(GRID_X);
  localparam int YW = $clog2(GRID_Y);
  localparam int ZW = $clog2(GRID_Z);
  localparam int IDX_W = (XW > YW) ? ((XW > ZW) ? XW : ZW) : ((YW > ZW) ? YW : ZW);

  localparam int ROW_CNT = GRID_Y * GRID_Z;
  localparam int ROW_AW = $clog2(ROW_CNT);

  localparam int POS_W = 20;
  localparam int SZ_W = 16;
  localparam int CIDX_W = 5;
  localparam int CORN_W = SZ_W + IDX_W;
  localparam int PROD_W = 2 * CORN_W;
  localparam int D2_W = PROD_W + 2;
  localparam int SQ_W = 2 * POS_W;

  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_QUERY = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  localparam logic [1:0] CFG_CELL_X = 2'd0;
  localparam logic [1:0] CFG_CELL_Y = 2'd1;
  localparam logic [1:0] CFG_CELL_Z = 2'd2;

  localparam logic [SZ_W-1:0] CELL_RST = 16'd256;

  typedef logic [POS_W-1:0] pos_t;
  typedef logic [SZ_W-1:0] size_t;
endpackage
`default_nettype wire

[hw/rtl/gno_if.sv]
// Handshake channels for input items and result items.
`default_nettype none
interface gno_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    mode;
  logic [gno_pkg::CIDX_W-1:0]    cell_x;
  logic [gno_pkg::CIDX_W-1:0]    cell_y;
  logic [gno_pkg::CIDX_W-1:0]    cell_z;
  logic                          occupied;
  logic [gno_pkg::POS_W-1:0]     pos_x;
  logic [gno_pkg::POS_W-1:0]     pos_y;
  logic [gno_pkg::POS_W-1:0]     pos_z;
  logic [gno_pkg::POS_W-1:0]     max_dist;
  modport source (output valid, mode, cell_x, cell_y, cell_z, occupied, pos_x, pos_y, pos_z,
                  max_dist, input ready);
  modport sink (input valid, mode, cell_x, cell_y, cell_z, occupied, pos_x, pos_y, pos_z,
                max_dist, output ready);
endinterface

interface gno_out_if;
  logic                      valid;
  logic                      ready;
  logic [gno_pkg::POS_W-1:0] distance;
  modport source (output valid, distance, input ready);
  modport sink (input valid, distance, output ready);
endinterface
`default_nettype wire

[hw/rtl/gno_div.sv]
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module gno_div (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [gno_pkg::POS_W-1:0] dividend,
  input  wire logic [gno_pkg::SZ_W-1:0]  divisor,
  output logic                           done,
  output logic [gno_pkg::POS_W-1:0]      quotient
);
  import gno_pkg::*;

  localparam int CNT_W = $clog2(POS_W + 1);

  logic [POS_W-1:0] dvd_r;
  logic [SZ_W-1:0]  dvs_r;
  logic [SZ_W-1:0]  rem_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [SZ_W:0]    rem_sh;
  logic             ge;

  assign rem_sh = {rem_r, dvd_r[POS_W-1]};
  assign ge = rem_sh >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        dvd_r <= dividend;
        dvs_r <= divisor;
        rem_r <= '0;
        cnt_r <= CNT_W'(POS_W);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= ge ? SZ_W'(rem_sh - {1'b0, dvs_r}) : rem_sh[SZ_W-1:0];
        dvd_r <= {dvd_r[POS_W-2:0], ge};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quotient = dvd_r;
endmodule
`default_nettype wire

[hw/rtl/gno_sqrt.sv]
// Floor integer square root, one result bit per cycle.
`default_nettype none
module gno_sqrt (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [gno_pkg::SQ_W-1:0]  radicand,
  output logic                           done,
  output logic [gno_pkg::POS_W-1:0]      root
);
  import gno_pkg::*;

  localparam int CNT_W = $clog2(POS_W + 1);

  logic [SQ_W-1:0]  v_r;
  logic [SQ_W-1:0]  res_r;
  logic [SQ_W-1:0]  bit_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [SQ_W-1:0]  trial;

  assign trial = res_r + bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        v_r <= radicand;
        res_r <= '0;
        bit_r <= SQ_W'(1) << (SQ_W - 2);
        cnt_r <= CNT_W'(POS_W);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (v_r >= trial) begin
          v_r <= v_r - trial;
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = res_r[POS_W-1:0];
endmodule
`default_nettype wire

[hw/rtl/grid_nearest_obstacle_distance.sv]
// Occupancy grid with nearest obstacle distance query: top level and sequencer.
// A write item reads and writes back one grid row; a clear item zeroes one grid row per
// cycle over all GRID_Y*GRID_Z rows (1024 at 32x32x32); the same clearing pass runs after
// reset with in ready low. A query squares the radius and runs six index and radius
// divisions, then visits each grid row of the search window (RY, RY2, RZ, RZ2, RX, CX) and
// each cell (CSQ, CCMP), serialised by the one shared multiplier, then runs the square root
// unit when an obstacle was found, and ends with boundary clamp and output.
// Results wait in an output register; a query finishing while it is full holds there.
`default_nettype none
module grid_nearest_obstacle_distance (
  input  wire logic              clk,
  input  wire logic              rst_n,
  gno_in_if.sink                 in_ch,
  gno_out_if.source              out_ch,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_idx,
  input  wire logic [gno_pkg::SZ_W-1:0] cfg_wdata
);
  import gno_pkg::*;

  localparam int ST_W = 5;
  localparam logic [ST_W-1:0] S_CLR  = 5'd0;
  localparam logic [ST_W-1:0] S_IDLE = 5'd1;
  localparam logic [ST_W-1:0] S_WRD  = 5'd2;
  localparam logic [ST_W-1:0] S_WRW  = 5'd3;
  localparam logic [ST_W-1:0] S_LSQ  = 5'd4;
  localparam logic [ST_W-1:0] S_DIV0 = 5'd5;
  localparam logic [ST_W-1:0] S_DIV  = 5'd6;
  localparam logic [ST_W-1:0] S_WIN  = 5'd7;
  localparam logic [ST_W-1:0] S_RY   = 5'd8;
  localparam logic [ST_W-1:0] S_RY2  = 5'd9;
  localparam logic [ST_W-1:0] S_RZ   = 5'd10;
  localparam logic [ST_W-1:0] S_RZ2  = 5'd11;
  localparam logic [ST_W-1:0] S_RX   = 5'd12;
  localparam logic [ST_W-1:0] S_CX   = 5'd13;
  localparam logic [ST_W-1:0] S_CSQ  = 5'd14;
  localparam logic [ST_W-1:0] S_CCMP = 5'd15;
  localparam logic [ST_W-1:0] S_SQRT = 5'd16;
  localparam logic [ST_W-1:0] S_BND  = 5'd17;
  localparam logic [ST_W-1:0] S_OUT  = 5'd18;

  logic [ST_W-1:0]   state_r;
  size_t             csx_r, csy_r, csz_r;
  size_t             sx, sy, sz;

  logic [GRID_X-1:0] mem [ROW_CNT];
  logic [GRID_X-1:0] row_r;
  logic [GRID_X-1:0] wrow;
  logic [ROW_AW-1:0] clr_cnt_r;
  logic [ROW_AW-1:0] waddr_r;
  logic [XW-1:0]     wbit_r;
  logic              wval_r;
  logic              wok;

  pos_t              px_r, py_r, pz_r, lim_r;
  pos_t              quot_r [6];
  logic [2:0]        div_idx_r;
  logic [2:0]        div_sel;
  logic              div_start, div_done;
  pos_t              div_dvd, div_q;
  size_t             div_dvs;

  logic [XW-1:0]     x0_r, x1_r, i_r;
  logic [YW-1:0]     y0_r, y1_r, j_r;
  logic [ZW-1:0]     z0_r, z1_r, k_r;
  logic [CORN_W-1:0] cx_r;
  logic [D2_W-1:0]   yz_r, best_r, d2;
  logic              found_r;
  pos_t              res_r;
  logic              out_valid_r;
  pos_t              out_dist_r;
  logic              out_load;

  logic [CORN_W-1:0] mul_a, mul_b;
  logic [PROD_W-1:0] mul_p_r;
  logic [CORN_W-1:0] dy, dz, dx;
  logic              sq_start, sq_done;
  logic              hit_now;
  logic [SQ_W-1:0]   sq_rad;
  pos_t              sq_root;
  logic              row_end, scan_end;
  logic [ROW_AW-1:0] rd_addr;

  assign sx = (csx_r == '0) ? SZ_W'(1) : csx_r;
  assign sy = (csy_r == '0) ? SZ_W'(1) : csy_r;
  assign sz = (csz_r == '0) ? SZ_W'(1) : csz_r;

  function automatic logic [CORN_W-1:0] absdiff(input pos_t p, input logic [CORN_W-1:0] c);
    logic [CORN_W-1:0] pe;
    pe = CORN_W'(p);
    return (pe >= c) ? pe - c : c - pe;
  endfunction

  function automatic logic [POS_W:0] win_lo(input pos_t c, input pos_t r);
    return (c > r) ? {1'b0, c - r} : '0;
  endfunction

  function automatic logic [POS_W:0] win_hi(input pos_t c, input pos_t r, input int n);
    logic [POS_W:0] h;
    h = {1'b0, c} + {1'b0, r};
    return (h > (POS_W+1)'(n - 1)) ? (POS_W+1)'(n - 1) : h;
  endfunction

  function automatic pos_t bnd(input pos_t best, input pos_t p, input size_t s, input int n);
    logic [CORN_W:0] world, far;
    pos_t            b;
    world = (CORN_W+1)'(s) * (CORN_W+1)'(n);
    far = (world > (CORN_W+1)'(p)) ? world - (CORN_W+1)'(p) : '0;
    b = (p < best) ? p : best;
    return (far < (CORN_W+1)'(b)) ? far[POS_W-1:0] : b;
  endfunction

  logic [POS_W:0] lo_x, hi_x, lo_y, hi_y, lo_z, hi_z;
  assign lo_x = win_lo(quot_r[0], quot_r[3]);
  assign hi_x = win_hi(quot_r[0], quot_r[3], GRID_X);
  assign lo_y = win_lo(quot_r[1], quot_r[4]);
  assign hi_y = win_hi(quot_r[1], quot_r[4], GRID_Y);
  assign lo_z = win_lo(quot_r[2], quot_r[5]);
  assign hi_z = win_hi(quot_r[2], quot_r[5], GRID_Z);

  assign dy = absdiff(py_r, mul_p_r[CORN_W-1:0]);
  assign dz = absdiff(pz_r, mul_p_r[CORN_W-1:0]);
  assign dx = absdiff(px_r, cx_r);
  assign d2 = yz_r + D2_W'(mul_p_r);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_LSQ:   begin mul_a = CORN_W'(lim_r); mul_b = CORN_W'(lim_r); end
      S_RY:    begin mul_a = CORN_W'(j_r); mul_b = CORN_W'(sy); end
      S_RY2:   begin mul_a = dy; mul_b = dy; end
      S_RZ:    begin mul_a = CORN_W'(k_r); mul_b = CORN_W'(sz); end
      S_RZ2:   begin mul_a = dz; mul_b = dz; end
      S_RX:    begin mul_a = CORN_W'(x0_r); mul_b = CORN_W'(sx); end
      S_CSQ:   begin mul_a = dx; mul_b = dx; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  always_comb begin
    wrow = row_r;
    wrow[wbit_r] = wval_r;
  end

  assign wok = (32'(in_ch.cell_x) < GRID_X) && (32'(in_ch.cell_y) < GRID_Y) &&
               (32'(in_ch.cell_z) < GRID_Z);
  assign rd_addr = ROW_AW'(j_r) + ROW_AW'(GRID_Y) * ROW_AW'(k_r);

  assign div_sel = (state_r == S_DIV0) ? 3'd0 : div_idx_r + 3'd1;
  assign div_start = (state_r == S_DIV0) || (state_r == S_DIV && div_done && div_idx_r != 3'd5);
  always_comb begin
    div_dvd = lim_r;
    div_dvs = sz;
    unique case (div_sel)
      3'd0:    begin div_dvd = px_r; div_dvs = sx; end
      3'd1:    begin div_dvd = py_r; div_dvs = sy; end
      3'd2:    begin div_dvd = pz_r; div_dvs = sz; end
      3'd3:    begin div_dvd = lim_r; div_dvs = sx; end
      3'd4:    begin div_dvd = lim_r; div_dvs = sy; end
      default: begin div_dvd = lim_r; div_dvs = sz; end
    endcase
  end

  gno_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_dvd), .divisor(div_dvs),
    .done(div_done), .quotient(div_q)
  );

  assign row_end = (i_r == x1_r);
  assign scan_end = row_end && (j_r == y1_r) && (k_r == z1_r);
  assign hit_now = row_r[i_r] && (d2 < best_r);
  assign sq_start = (state_r == S_CCMP) && scan_end && (found_r || hit_now);
  assign sq_rad = hit_now ? d2[SQ_W-1:0] : best_r[SQ_W-1:0];

  gno_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(sq_start), .radicand(sq_rad),
    .done(sq_done), .root(sq_root)
  );

  always_ff @(posedge clk) begin
    mul_p_r <= mul_a * mul_b;
    if (state_r == S_CLR) begin
      mem[clr_cnt_r] <= '0;
    end else if (state_r == S_WRW) begin
      mem[waddr_r] <= wrow;
    end
    if (state_r == S_WRD) begin
      row_r <= mem[waddr_r];
    end else if (state_r == S_RY) begin
      row_r <= mem[rd_addr];
    end
  end

  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_cnt_r <= '0;
      csx_r <= CELL_RST;
      csy_r <= CELL_RST;
      csz_r <= CELL_RST;
      out_valid_r <= 1'b0;
      found_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_CELL_X: csx_r <= cfg_wdata;
          CFG_CELL_Y: csy_r <= cfg_wdata;
          CFG_CELL_Z: csz_r <= cfg_wdata;
          default:    ;
        endcase
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r == ROW_AW'(ROW_CNT - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_ch.valid) begin
            waddr_r <= ROW_AW'(in_ch.cell_y) + ROW_AW'(GRID_Y) * ROW_AW'(in_ch.cell_z);
            wbit_r <= XW'(in_ch.cell_x);
            wval_r <= in_ch.occupied;
            px_r <= in_ch.pos_x;
            py_r <= in_ch.pos_y;
            pz_r <= in_ch.pos_z;
            lim_r <= in_ch.max_dist;
            clr_cnt_r <= '0;
            unique case (in_ch.mode)
              MODE_WRITE: state_r <= wok ? S_WRD : S_IDLE;
              MODE_QUERY: state_r <= S_LSQ;
              MODE_CLEAR: state_r <= S_CLR;
              default:    state_r <= S_IDLE;
            endcase
          end
        end
        S_WRD: state_r <= S_WRW;
        S_WRW: state_r <= S_IDLE;
        S_LSQ: state_r <= S_DIV0;
        S_DIV0: begin
          best_r <= D2_W'(mul_p_r);
          found_r <= 1'b0;
          res_r <= lim_r;
          div_idx_r <= 3'd0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            quot_r[div_idx_r] <= div_q;
            if (div_idx_r == 3'd5) begin
              state_r <= S_WIN;
            end else begin
              div_idx_r <= div_idx_r + 3'd1;
            end
          end
        end
        S_WIN: begin
          x0_r <= XW'(lo_x); x1_r <= XW'(hi_x);
          y0_r <= YW'(lo_y); y1_r <= YW'(hi_y);
          z0_r <= ZW'(lo_z); z1_r <= ZW'(hi_z);
          j_r <= YW'(lo_y);
          k_r <= ZW'(lo_z);
          if (lo_x > hi_x || lo_y > hi_y || lo_z > hi_z) begin
            state_r <= S_BND;
          end else begin
            state_r <= S_RY;
          end
        end
        S_RY:  state_r <= S_RY2;
        S_RY2: state_r <= S_RZ;
        S_RZ: begin
          yz_r <= D2_W'(mul_p_r);
          state_r <= S_RZ2;
        end
        S_RZ2: state_r <= S_RX;
        S_RX: begin
          yz_r <= yz_r + D2_W'(mul_p_r);
          state_r <= S_CX;
        end
        S_CX: begin
          cx_r <= mul_p_r[CORN_W-1:0];
          i_r <= x0_r;
          state_r <= S_CSQ;
        end
        S_CSQ: state_r <= S_CCMP;
        S_CCMP: begin
          if (hit_now) begin
            best_r <= d2;
            found_r <= 1'b1;
          end
          if (!row_end) begin
            i_r <= i_r + 1'b1;
            cx_r <= cx_r + CORN_W'(sx);
            state_r <= S_CSQ;
          end else if (scan_end) begin
            state_r <= sq_start ? S_SQRT : S_BND;
          end else begin
            if (j_r == y1_r) begin
              j_r <= y0_r;
              k_r <= k_r + 1'b1;
            end else begin
              j_r <= j_r + 1'b1;
            end
            state_r <= S_RY;
          end
        end
        S_SQRT: begin
          if (sq_done) begin
            res_r <= sq_root;
            state_r <= S_BND;
          end
        end
        S_BND: begin
          res_r <= bnd(bnd(bnd(res_r, px_r, sx, GRID_X), py_r, sy, GRID_Y), pz_r, sz, GRID_Z);
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            out_dist_r <= res_r;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready = (state_r == S_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.distance = out_dist_r;
endmodule
`default_nettype wire

[hw/rtl/gno_chk.sv]
// Port-level checker for the grid distance block, bound to the top level.
`default_nettype none
module gno_chk (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic [1:0] in_mode,
  input wire logic       out_valid,
  input wire logic       out_ready
);
  import gno_pkg::*;

  a_rst_busy: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("input ready during clearing after reset");

  a_busy_after: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_mode == MODE_WRITE || in_mode == MODE_QUERY ||
    in_mode == MODE_CLEAR) |=> !in_ready)
    else $error("input ready right after a transfer");

  a_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_mode != MODE_QUERY |=> !$rose(out_valid))
    else $error("result after a non-query transfer");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");
endmodule

bind grid_nearest_obstacle_distance gno_chk u_gno_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .in_mode(in_ch.mode), .out_valid(out_ch.valid), .out_ready(out_ch.ready)
);
`default_nettype wire

[verif/tb.sv]
// Testbench for the occupancy grid nearest obstacle distance block.
`timescale 1ns / 100ps
`default_nettype none
module tb;
  import gno_pkg::*;

  localparam logic [1:0] MODE_NONE = 2'd3;
  localparam int CELLS = GRID_X * GRID_Y * GRID_Z;
  localparam int SETTLE = 1200;
  localparam longint CYCLE_LIMIT = 10000000;
  localparam int PHASE_ITEMS = 375;

  typedef struct {
    logic [1:0]        mode;
    logic [CIDX_W-1:0] cx;
    logic [CIDX_W-1:0] cy;
    logic [CIDX_W-1:0] cz;
    logic              occ;
    pos_t              px;
    pos_t              py;
    pos_t              pz;
    pos_t              lim;
    bit                typed;
    pos_t              exp_dist;
  } grid_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_idx = CFG_CELL_X;
  size_t cfg_wdata = '0;

  gno_in_if in_ch ();
  gno_out_if out_ch ();

  grid_nearest_obstacle_distance DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  bit occ_map [CELLS];
  size_t cell_sz [3];
  pos_t dist_q [$];
  int errors = 0;
  int queries = 0;
  int results = 0;
  int sent = 0;
  longint cycles = 0;
  int burst_left = 1;
  int gap_left = 0;

  function automatic longint unsigned eff_sz(size_t s);
    return (s == 0) ? 1 : s;
  endfunction

  function automatic bit axis_span(longint unsigned p, longint unsigned c,
                                   longint unsigned lim, longint unsigned n,
                                   output longint unsigned lo, output longint unsigned hi);
    longint unsigned ci;
    longint unsigned r;
    ci = p / c;
    r = lim / c;
    lo = (ci > r) ? ci - r : 0;
    hi = ci + r;
    if (hi > n - 1) hi = n - 1;
    return lo <= hi;
  endfunction

  function automatic longint unsigned off_sq(longint unsigned p, longint unsigned i,
                                             longint unsigned c);
    longint unsigned corner;
    longint unsigned d;
    corner = i * c;
    d = (p >= corner) ? p - corner : corner - p;
    return d * d;
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned clamp_wall(longint unsigned best, longint unsigned p,
                                                 longint unsigned world);
    longint unsigned far_d;
    far_d = (world > p) ? world - p : 0;
    if (p < best) best = p;
    if (far_d < best) best = far_d;
    return best;
  endfunction

  function automatic pos_t nearest_dist(pos_t px, pos_t py, pos_t pz, pos_t lim);
    longint unsigned sx, sy, sz, best_sq, d2, res;
    longint unsigned x0, x1, y0, y1, z0, z1;
    bit hit;
    sx = eff_sz(cell_sz[0]);
    sy = eff_sz(cell_sz[1]);
    sz = eff_sz(cell_sz[2]);
    best_sq = longint'(lim) * longint'(lim);
    hit = 0;
    res = lim;
    if (axis_span(px, sx, lim, GRID_X, x0, x1) && axis_span(py, sy, lim, GRID_Y, y0, y1) &&
        axis_span(pz, sz, lim, GRID_Z, z0, z1)) begin
      for (longint unsigned i = x0; i <= x1; i++)
        for (longint unsigned j = y0; j <= y1; j++)
          for (longint unsigned k = z0; k <= z1; k++)
            if (occ_map[i + GRID_X * (j + GRID_Y * k)]) begin
              d2 = off_sq(px, i, sx) + off_sq(py, j, sy) + off_sq(pz, k, sz);
              if (d2 < best_sq) begin
                best_sq = d2;
                hit = 1;
              end
            end
    end
    if (hit) res = floor_sqrt(best_sq);
    res = clamp_wall(res, px, GRID_X * sx);
    res = clamp_wall(res, py, GRID_Y * sy);
    res = clamp_wall(res, pz, GRID_Z * sz);
    return pos_t'(res);
  endfunction

  function automatic void apply_item(grid_item_t it);
    case (it.mode)
      MODE_WRITE: occ_map[it.cx + GRID_X * (it.cy + GRID_Y * it.cz)] = it.occ;
      MODE_CLEAR: foreach (occ_map[a]) occ_map[a] = 0;
      MODE_QUERY: begin
        dist_q.push_back(it.typed ? it.exp_dist : nearest_dist(it.px, it.py, it.pz, it.lim));
        queries++;
      end
      default: ;
    endcase
  endfunction

  task automatic report(string what, pos_t got, pos_t want);
    errors++;
    $display("mismatch %0s: got %0d, expected %0d at cycle %0d", what, got, want, cycles);
  endtask

  task automatic transfer(grid_item_t it);
    while (gap_left > 0) begin
      @(posedge clk);
      gap_left--;
    end
    in_ch.valid <= 1'b1;
    in_ch.mode <= it.mode;
    in_ch.cell_x <= it.cx;
    in_ch.cell_y <= it.cy;
    in_ch.cell_z <= it.cz;
    in_ch.occupied <= it.occ;
    in_ch.pos_x <= it.px;
    in_ch.pos_y <= it.py;
    in_ch.pos_z <= it.pz;
    in_ch.max_dist <= it.lim;
    do @(posedge clk); while (!in_ch.ready);
    apply_item(it);
    sent++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 12);
      gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap_left > 0) in_ch.valid <= 1'b0;
    end
  endtask

  task automatic drain();
    while (dist_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_sizes(size_t sx, size_t sy, size_t sz);
    size_t v [3];
    v = '{sx, sy, sz};
    for (int i = 0; i < 3; i++) begin
      cfg_we <= 1'b1;
      cfg_idx <= 2'(i);
      cfg_wdata <= v[i];
      @(posedge clk);
      cell_sz[i] = v[i];
    end
    cfg_we <= 1'b0;
  endtask

  function automatic grid_item_t rand_item();
    grid_item_t it;
    longint unsigned s [3];
    longint unsigned minc, r, lim, top;
    int pick;
    it = '{default: '0};
    for (int i = 0; i < 3; i++) s[i] = eff_sz(cell_sz[i]);
    minc = s[0];
    if (s[1] < minc) minc = s[1];
    if (s[2] < minc) minc = s[2];
    it.cx = CIDX_W'($urandom); it.cy = CIDX_W'($urandom); it.cz = CIDX_W'($urandom);
    it.occ = 1'($urandom);
    it.px = POS_W'($urandom); it.py = POS_W'($urandom); it.pz = POS_W'($urandom);
    it.lim = POS_W'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      it.mode = MODE_WRITE;
      it.occ = ($urandom_range(0, 4) != 0);
    end else if (pick < 95) begin
      it.mode = MODE_QUERY;
      if ($urandom_range(0, 19) != 0) begin
        top = GRID_X * s[0] + s[0];
        it.px = POS_W'($urandom_range(0, 32'((top > 20'hFFFFF) ? 20'hFFFFF : top)));
        top = GRID_Y * s[1] + s[1];
        it.py = POS_W'($urandom_range(0, 32'((top > 20'hFFFFF) ? 20'hFFFFF : top)));
        top = GRID_Z * s[2] + s[2];
        it.pz = POS_W'($urandom_range(0, 32'((top > 20'hFFFFF) ? 20'hFFFFF : top)));
      end
      pick = $urandom_range(0, 99);
      r = (pick < 60) ? $urandom_range(0, 1) : (pick < 90) ? 2 : 3;
      lim = r * minc + $urandom_range(0, 32'(minc - 1));
      it.lim = POS_W'((lim > 20'hFFFFF) ? 20'hFFFFF : lim);
    end else if (pick < 98) begin
      it.mode = MODE_NONE;
    end else if (pick < 99) begin
      it.mode = MODE_CLEAR;
    end else begin
      it.mode = MODE_WRITE;
      it.cx = CIDX_W'(it.px / s[0]);
      it.cy = CIDX_W'(it.py / s[1]);
      it.cz = CIDX_W'(it.pz / s[2]);
    end
    return it;
  endfunction

  grid_item_t steps [] = '{
    '{MODE_QUERY, 0, 0, 0, 0, 4096, 4096, 4096, 20'hFFFFF, 1, 4096},
    '{MODE_QUERY, 0, 0, 0, 0, 0, 0, 0, 100, 1, 0},
    '{MODE_QUERY, 0, 0, 0, 0, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 5, 1, 0},
    '{MODE_NONE, 31, 31, 31, 1, 20'hFFFFF, 0, 0, 0, 0, 0},
    '{MODE_WRITE, 31, 31, 31, 1, 0, 0, 0, 0, 0, 0},
    '{MODE_WRITE, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0},
    '{MODE_WRITE, 5, 6, 7, 1, 0, 0, 0, 0, 0, 0},
    '{MODE_WRITE, 16, 16, 16, 1, 0, 0, 0, 0, 0, 0},
    '{MODE_QUERY, 0, 0, 0, 0, 4096, 4096, 4096, 1000, 1, 0},
    '{MODE_QUERY, 0, 0, 0, 0, 1290, 1536, 1792, 300, 1, 10},
    '{MODE_QUERY, 0, 0, 0, 0, 8000, 8000, 8000, 400, 0, 0},
    '{MODE_QUERY, 0, 0, 0, 0, 100, 60, 30, 20'hFFF, 0, 0},
    '{MODE_WRITE, 5, 6, 7, 0, 0, 0, 0, 0, 0, 0},
    '{MODE_QUERY, 0, 0, 0, 0, 1290, 1536, 1792, 300, 1, 300},
    '{MODE_QUERY, 0, 0, 0, 0, 4352, 4096, 4096, 256, 0, 0},
    '{MODE_QUERY, 0, 0, 0, 0, 4353, 4100, 4096, 300, 0, 0},
    '{MODE_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{MODE_QUERY, 0, 0, 0, 0, 4096, 4096, 4096, 1000, 1, 1000},
    '{MODE_WRITE, 31, 0, 31, 1, 0, 0, 0, 0, 0, 0},
    '{MODE_QUERY, 0, 0, 0, 0, 7936, 0, 7936, 0, 1, 0},
    '{MODE_QUERY, 0, 0, 0, 0, 7940, 3, 7950, 40, 0, 0}
  };

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, dist_q.size());
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    case (cycles[10:9])
      2'd0: out_ch.ready <= 1'b1;
      2'd1: out_ch.ready <= ($urandom_range(0, 3) != 0);
      2'd2: out_ch.ready <= ($urandom_range(0, 7) == 0);
      default: out_ch.ready <= cycles[4];
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results++;
      if (dist_q.size() == 0) report("unexpected result", out_ch.distance, '0);
      else begin
        if (out_ch.distance !== dist_q[0]) report("distance", out_ch.distance, dist_q[0]);
        void'(dist_q.pop_front());
      end
    end
  end

  initial begin
    size_t plan [4][3];
    plan = '{'{16'd1, 16'd1, 16'd1}, '{16'hFFFF, 16'hFFFF, 16'hFFFF},
             '{16'd0, 16'd300, 16'd77}, '{16'd256, 16'd256, 16'd256}};
    in_ch.valid = 1'b0;
    in_ch.mode = MODE_WRITE;
    in_ch.cell_x = '0; in_ch.cell_y = '0; in_ch.cell_z = '0;
    in_ch.occupied = 1'b0;
    in_ch.pos_x = '0; in_ch.pos_y = '0; in_ch.pos_z = '0;
    in_ch.max_dist = '0;
    out_ch.ready = 1'b0;
    foreach (occ_map[a]) occ_map[a] = 0;
    foreach (cell_sz[i]) cell_sz[i] = CELL_RST;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (steps[i]) transfer(steps[i]);
    for (int ph = 0; ph < 4; ph++) begin
      if (gap_left == 0) in_ch.valid <= 1'b0;
      drain();
      set_sizes(plan[ph][0], plan[ph][1], plan[ph][2]);
      gap_left = 0;
      for (int n = 0; n < PHASE_ITEMS; n++) transfer(rand_item());
    end
    if (gap_left == 0) in_ch.valid <= 1'b0;
    drain();
    $display("sent %0d items (%0d queries) over 5 cell size settings", sent, queries);
    $display("checked %0d distance results, %0d mismatches", results, errors);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule
`default_nettype wire
